// ----- src/hlmd_pkg.sv -----
// Shared types, codes and constants of the header/length message deframer.
package hlmd_pkg;

   // Default width bound of the Length header value
   localparam int LENGTH_BITS_DEFAULT = 32;

   // Stream phase; the unused code is treated as malformed
   typedef enum logic [1:0] {
      PH_HEADERS = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_BAD     = 2'd2
   } phase_type;

   // Progress of the first colon on a header line
   typedef enum logic [1:0] {
      COLON_NONE  = 2'd0,
      COLON_JUST  = 2'd1,
      COLON_SPACE = 2'd2,
      COLON_OTHER = 2'd3
   } colon_type;

   // UTF-8 checker status of the current line
   typedef enum logic [1:0] {
      U8_CHECKING = 2'd0,
      U8_NUL_STOP = 2'd1,
      U8_ERROR    = 2'd2
   } utf8_stat_type;

   // Allowed range of the next continuation byte
   typedef enum logic [2:0] {
      RULE_80_BF = 3'd0,
      RULE_A0_BF = 3'd1,
      RULE_80_9F = 3'd2,
      RULE_90_BF = 3'd3,
      RULE_80_8F = 3'd4
   } utf8_rule_type;

   // Class tag of a passed byte
   typedef enum logic [1:0] {
      CLS_HEADER  = 2'd0,
      CLS_BLANK   = 2'd1,
      CLS_PAYLOAD = 2'd2,
      CLS_DROPPED = 2'd3
   } class_type;

   // Positions of the Length prefix matcher
   localparam logic [3:0] POS_START  = 4'd0;
   localparam logic [3:0] POS_VALUE  = 4'd8;
   localparam logic [3:0] POS_NULEND = 4'd9;
   localparam logic [3:0] POS_NONE   = 4'd15;

   // Characters
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3A;

   // UTF-8 checker state of one line
   typedef struct packed {
      utf8_stat_type status;
      logic [1:0]    pending;
      utf8_rule_type rule;
   } utf8_state_type;

   // One result transaction
   typedef struct packed {
      logic [31:0] plen;
      logic        bad;
      logic        done;
      class_type   cls;
      logic [7:0]  data;
   } result_type;

   // Characters of the "Length: " prefix
   function automatic logic [7:0] prefix_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = 8'h4C;
         3'd1:    ch = 8'h65;
         3'd2:    ch = 8'h6E;
         3'd3:    ch = 8'h67;
         3'd4:    ch = 8'h74;
         3'd5:    ch = 8'h68;
         3'd6:    ch = CH_COLON;
         default: ch = CH_SPACE;
      endcase
      return ch;
   endfunction

endpackage

// ----- src/hlmd_utf8_check.sv -----
// Next state of the per-line UTF-8 checker for one header byte.
module hlmd_utf8_check (
   input  logic [7:0]              data_byte,
   input  hlmd_pkg::utf8_state_type cur,
   output hlmd_pkg::utf8_state_type nxt
);
   import hlmd_pkg::*;

   logic [7:0] range_lo;
   logic [7:0] range_hi;

   // Decode the allowed continuation range
   always_comb begin
      range_lo = 8'h80;
      range_hi = 8'hBF;
      case (cur.rule)
         RULE_A0_BF: range_lo = 8'hA0;
         RULE_80_9F: range_hi = 8'h9F;
         RULE_90_BF: range_lo = 8'h90;
         RULE_80_8F: range_hi = 8'h8F;
         default:    range_lo = 8'h80;
      endcase
   end

   // Advance the checker; stop at NUL or on the first error
   always_comb begin
      nxt = cur;
      if (cur.status == U8_CHECKING) begin
         if (data_byte == CH_NUL) begin
            nxt.status = (cur.pending != 2'd0) ? U8_ERROR : U8_NUL_STOP;
         end else if (cur.pending != 2'd0) begin
            if (data_byte < range_lo || data_byte > range_hi) begin
               nxt.status = U8_ERROR;
            end else begin
               nxt.rule    = RULE_80_BF;
               nxt.pending = cur.pending - 2'd1;
            end
         end else begin
            nxt.rule = RULE_80_BF;
            if (data_byte < 8'h80) begin
               nxt.pending = 2'd0;
            end else if (data_byte < 8'hC2 || data_byte > 8'hF4) begin
               nxt.status = U8_ERROR;
            end else if (data_byte < 8'hE0) begin
               nxt.pending = 2'd1;
            end else if (data_byte < 8'hF0) begin
               nxt.pending = 2'd2;
               if (data_byte == 8'hE0) begin
                  nxt.rule = RULE_A0_BF;
               end else if (data_byte == 8'hED) begin
                  nxt.rule = RULE_80_9F;
               end
            end else begin
               nxt.pending = 2'd3;
               if (data_byte == 8'hF0) begin
                  nxt.rule = RULE_90_BF;
               end else if (data_byte == 8'hF4) begin
                  nxt.rule = RULE_80_8F;
               end
            end
         end
      end
   end

endmodule

// ----- src/hlmd_parser.sv -----
// Deframer state and the single-pass step that tags one byte.
module hlmd_parser #(
   parameter int LENGTH_BITS = hlmd_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic [7:0]           data_byte,
   output hlmd_pkg::result_type result
);
   import hlmd_pkg::*;

   localparam int AccBits = (LENGTH_BITS > 32) ? 32 : LENGTH_BITS;

   phase_type            phase_ff, phase_in;
   logic                 line_start_ff, line_start_in;
   colon_type            colon_ff, colon_in;
   utf8_state_type       utf8_ff, utf8_in, utf8_step;
   logic [3:0]           pos_ff, pos_in;
   logic                 found_ff, found_in;
   logic                 bad_digit_ff, bad_digit_in;
   logic                 overflow_ff, overflow_in;
   logic [AccBits-1:0]   accum_ff, accum_in;
   logic [31:0]          remain_ff, remain_in;

   logic                 is_lf;
   logic                 is_digit;
   logic                 utf_ok;
   logic                 value_pos;
   logic [31:0]          remain_dec;
   logic [AccBits+3:0]   accum_x10;

   hlmd_utf8_check u_utf8 (
      .data_byte (data_byte),
      .cur       (utf8_ff),
      .nxt       (utf8_step)
   );

   // Decode the byte and the current line
   assign is_lf      = (data_byte == CH_LF);
   assign is_digit   = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
   assign utf_ok     = (utf8_ff.status == U8_NUL_STOP) ||
                       (utf8_ff.status == U8_CHECKING && utf8_ff.pending == 2'd0);
   assign value_pos  = (pos_ff == POS_VALUE) || (pos_ff == POS_NULEND);
   assign remain_dec = remain_ff - 32'(remain_ff != 32'd0);
   // Multiply-by-ten accumulate; any upper bit set is overflow
   assign accum_x10  = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0} +
                       (AccBits + 4)'(data_byte - CH_ZERO);

   // Next state
   always_comb begin
      phase_in      = phase_ff;
      line_start_in = line_start_ff;
      colon_in      = colon_ff;
      utf8_in       = utf8_ff;
      pos_in        = pos_ff;
      found_in      = found_ff;
      bad_digit_in  = bad_digit_ff;
      overflow_in   = overflow_ff;
      accum_in      = accum_ff;
      remain_in     = remain_ff;
      case (phase_ff)
         PH_PAYLOAD: begin
            remain_in = remain_dec;
            if (remain_dec == 32'd0) begin
               phase_in      = PH_HEADERS;
               found_in      = 1'b0;
               bad_digit_in  = 1'b0;
               overflow_in   = 1'b0;
               accum_in      = '0;
               line_start_in = 1'b1;
               colon_in      = COLON_NONE;
               utf8_in       = '{U8_CHECKING, 2'd0, RULE_80_BF};
               pos_in        = POS_START;
            end
         end
         PH_HEADERS: begin
            if (is_lf && line_start_ff) begin
               if (bad_digit_ff || overflow_ff) begin
                  phase_in = PH_BAD;
               end else if (accum_ff == '0) begin
                  found_in      = 1'b0;
                  remain_in     = 32'd0;
                  line_start_in = 1'b1;
                  colon_in      = COLON_NONE;
                  utf8_in       = '{U8_CHECKING, 2'd0, RULE_80_BF};
                  pos_in        = POS_START;
               end else begin
                  remain_in = 32'(accum_ff);
                  phase_in  = PH_PAYLOAD;
               end
            end else if (is_lf) begin
               if (!utf_ok || colon_ff != COLON_SPACE) begin
                  phase_in = PH_BAD;
               end else begin
                  found_in      = found_ff | value_pos;
                  line_start_in = 1'b1;
                  colon_in      = COLON_NONE;
                  utf8_in       = '{U8_CHECKING, 2'd0, RULE_80_BF};
                  pos_in        = (found_ff | value_pos) ? POS_NONE : POS_START;
               end
            end else begin
               line_start_in = 1'b0;
               utf8_in       = utf8_step;
               // Track the first colon and the byte after it
               if (colon_ff == COLON_JUST) begin
                  colon_in = (data_byte == CH_SPACE) ? COLON_SPACE : COLON_OTHER;
               end else if (colon_ff == COLON_NONE && data_byte == CH_COLON) begin
                  colon_in = COLON_JUST;
               end
               // Match the prefix, then parse the value
               if (pos_ff < POS_VALUE) begin
                  pos_in = (data_byte == prefix_char(pos_ff[2:0])) ? pos_ff + 4'd1
                                                                   : POS_NONE;
               end else if (pos_ff == POS_VALUE) begin
                  if (data_byte == CH_NUL) begin
                     pos_in = POS_NULEND;
                  end else if (!is_digit) begin
                     bad_digit_in = 1'b1;
                  end else if (!overflow_ff) begin
                     if (accum_x10[AccBits+3:AccBits] != 4'd0) begin
                        overflow_in = 1'b1;
                     end else begin
                        accum_in = accum_x10[AccBits-1:0];
                     end
                  end
               end
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   // Result of the byte
   always_comb begin
      result      = '0;
      result.data = data_byte;
      case (phase_ff)
         PH_PAYLOAD: begin
            result.cls  = CLS_PAYLOAD;
            result.done = (remain_dec == 32'd0);
         end
         PH_HEADERS: begin
            if (is_lf && line_start_ff) begin
               result.cls = CLS_BLANK;
               if (bad_digit_ff || overflow_ff) begin
                  result.bad = 1'b1;
               end else begin
                  result.plen = 32'(accum_ff);
                  result.done = (accum_ff == '0);
               end
            end else begin
               result.cls = CLS_HEADER;
               result.bad = is_lf && (!utf_ok || colon_ff != COLON_SPACE);
            end
         end
         default: begin
            result.cls = CLS_DROPPED;
            result.bad = 1'b1;
         end
      endcase
   end

   // Hold state; advance on each step
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADERS;
         line_start_ff <= 1'b1;
         colon_ff      <= COLON_NONE;
         utf8_ff       <= '{U8_CHECKING, 2'd0, RULE_80_BF};
         pos_ff        <= POS_START;
         found_ff      <= 1'b0;
         bad_digit_ff  <= 1'b0;
         overflow_ff   <= 1'b0;
         accum_ff      <= '0;
         remain_ff     <= 32'd0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         line_start_ff <= line_start_in;
         colon_ff      <= colon_in;
         utf8_ff       <= utf8_in;
         pos_ff        <= pos_in;
         found_ff      <= found_in;
         bad_digit_ff  <= bad_digit_in;
         overflow_ff   <= overflow_in;
         accum_ff      <= accum_in;
         remain_ff     <= remain_in;
      end
   end

`ifndef SYNTHESIS
   a_bad_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BAD |=> phase_ff == PH_BAD)
      else $error("malformed phase left before reset");
   a_payload_owed: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> remain_ff != 32'd0)
      else $error("payload phase with nothing left to pass");
   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      step_en && result.done |-> !result.bad && phase_in == PH_HEADERS)
      else $error("message completed on a malformed byte");
   a_plen_blank: assert property (@(posedge clock) disable iff (reset)
      step_en && result.plen != 32'd0 |-> result.cls == CLS_BLANK && phase_in == PH_PAYLOAD)
      else $error("payload length outside a good blank line");
`endif

endmodule

// ----- src/header_length_message_deframer_core.sv -----
// Top level of the header/length message deframer: input and result registers.
//
//   channel  direction  tdata                               tuser                   tlast
//   req_     in         [7:0] data_byte                     -                       -
//   rsp_     out        [7:0] out_byte, [39:8] payload_len  [1:0] class, [2] malf.  message_done
//
// One byte per cycle sustained while the result channel is not stalled; a byte's result is presented
// after it passes the input register, then single-pass tagging logic into the result register.
// The multiply-by-ten accumulate of the Length value sets the longest path.
// reset (synchronous) returns the deframer to the start of a message and empties both
// registers. A stalled result holds; the input register keeps taking a byte while
// the result register drains in the same cycle.
module header_length_message_deframer_core #(
   parameter int LENGTH_BITS = hlmd_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] out_byte, [39:8] payload_length
   output logic [2:0]  rsp_tuser,   // [1:0] byte_class, [2] malformed
   output logic        rsp_tlast    // message_done
);
   import hlmd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   result_type step_result;
   logic       advance;
   logic       req_take;

   // Move the held byte on when the result register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   hlmd_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .data_byte (in_byte_ff),
      .result    (step_result)
   );

   // Load or drain both registers
   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_byte_in   = req_take ? req_tdata : in_byte_ff;
      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      out_in       = advance ? step_result : out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   // Drive the result channel
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.plen, out_ff.data};
   assign rsp_tuser  = {out_ff.bad, out_ff.cls};
   assign rsp_tlast  = out_ff.done;

`ifndef SYNTHESIS
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held input byte lost before its step");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |-> !advance)
      else $error("result overwritten while stalled");
   a_drop_malformed: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.cls == CLS_DROPPED |-> out_ff.bad && !out_ff.done)
      else $error("dropped byte without malformed flag");
`endif

endmodule

// ----- tb/sv/deframer_checker.sv -----
// Result checker for the header/length message deframer: tracks the stream and compares results.
`timescale 1ns / 1ps

module deframer_checker #(
   parameter int LENGTH_BITS = hlmd_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [7:0]        req_tdata,    // [7:0] data_byte
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [39:0]       rsp_tdata,    // [7:0] out_byte, [39:8] payload_length
   input  logic [2:0]        rsp_tuser,    // [1:0] byte_class, [2] malformed
   input  logic              rsp_tlast,    // message_done
   output int unsigned       fail_count,
   output int unsigned       pending,
   output int unsigned       results_checked,
   output int unsigned       messages_done
);

   import hlmd_pkg::*;

   localparam int          VALUE_BITS  = (LENGTH_BITS > 32) ? 32 : LENGTH_BITS;
   localparam logic [63:0] VALUE_MAX   = (64'd1 << VALUE_BITS) - 64'd1;
   localparam logic [63:0] LEN_TAG     = "Length: ";

   // Tracked stream state
   phase_type     st_phase;
   logic          line_start;
   colon_type     colon_st;
   logic [1:0]    u8_owed;
   utf8_rule_type u8_rule;
   utf8_stat_type u8_st;
   logic [3:0]    match_pos;
   logic          len_found;
   logic          len_bad;
   logic          len_over;
   logic [63:0]   len_value;
   logic [31:0]   pay_left;

   result_type    expected_q [$];
   int unsigned   errors;
   int unsigned   checked;
   int unsigned   completed;

   // Clear the per-line checks; a found Length header disables the prefix matcher
   function automatic void start_line();
      line_start = 1'b1;
      colon_st   = COLON_NONE;
      u8_owed    = 2'd0;
      u8_rule    = RULE_80_BF;
      u8_st      = U8_CHECKING;
      match_pos  = len_found ? POS_NONE : POS_START;
   endfunction

   function automatic void start_message();
      len_found = 1'b0;
      len_bad   = 1'b0;
      len_over  = 1'b0;
      len_value = 64'd0;
      pay_left  = 32'd0;
      start_line();
   endfunction

   // Advance the tracked state by one byte and return its tagged result
   function automatic result_type deframe_byte(input logic [7:0] b);
      result_type  r;
      logic [7:0]  lo;
      logic [7:0]  hi;
      logic [63:0] digit;
      bit          utf_ok;
      r      = '0;
      r.data = b;
      r.cls  = CLS_HEADER;
      case (st_phase)
         PH_PAYLOAD: begin
            r.cls = CLS_PAYLOAD;
            if (pay_left != 32'd0) pay_left = pay_left - 32'd1;
            if (pay_left == 32'd0) begin
               r.done   = 1'b1;
               st_phase = PH_HEADERS;
               start_message();
            end
         end
         PH_HEADERS: begin
            if (b == CH_LF && line_start) begin
               // Blank line: settle the payload size
               r.cls = CLS_BLANK;
               if (len_bad || len_over) begin
                  st_phase = PH_BAD;
                  r.bad    = 1'b1;
               end else begin
                  r.plen = len_value[31:0];
                  if (r.plen == 32'd0) begin
                     r.done = 1'b1;
                     start_message();
                  end else begin
                     pay_left = r.plen;
                     st_phase = PH_PAYLOAD;
                  end
               end
            end else if (b == CH_LF) begin
               // End of a header line: judge it
               utf_ok = (u8_st == U8_NUL_STOP) || (u8_st == U8_CHECKING && u8_owed == 2'd0);
               if (!utf_ok || colon_st != COLON_SPACE) begin
                  st_phase = PH_BAD;
                  r.bad    = 1'b1;
               end else begin
                  if (match_pos == POS_VALUE || match_pos == POS_NULEND) len_found = 1'b1;
                  start_line();
               end
            end else begin
               line_start = 1'b0;

               // First colon and the byte after it
               if (colon_st == COLON_JUST)
                  colon_st = (b == CH_SPACE) ? COLON_SPACE : COLON_OTHER;
               else if (colon_st == COLON_NONE && b == CH_COLON)
                  colon_st = COLON_JUST;

               // UTF-8 check, stopped by a NUL
               if (u8_st == U8_CHECKING) begin
                  if (b == CH_NUL) begin
                     u8_st = (u8_owed != 2'd0) ? U8_ERROR : U8_NUL_STOP;
                  end else if (u8_owed != 2'd0) begin
                     lo = 8'h80;
                     hi = 8'hBF;
                     case (u8_rule)
                        RULE_A0_BF: lo = 8'hA0;
                        RULE_80_9F: hi = 8'h9F;
                        RULE_90_BF: lo = 8'h90;
                        RULE_80_8F: hi = 8'h8F;
                        default: ;
                     endcase
                     if (b < lo || b > hi) begin
                        u8_st = U8_ERROR;
                     end else begin
                        u8_rule = RULE_80_BF;
                        u8_owed = u8_owed - 2'd1;
                     end
                  end else begin
                     u8_rule = RULE_80_BF;
                     if (b >= 8'h80) begin
                        if (b < 8'hC2 || b > 8'hF4) begin
                           u8_st = U8_ERROR;
                        end else if (b < 8'hE0) begin
                           u8_owed = 2'd1;
                        end else if (b < 8'hF0) begin
                           u8_owed = 2'd2;
                           if (b == 8'hE0) u8_rule = RULE_A0_BF;
                           else if (b == 8'hED) u8_rule = RULE_80_9F;
                        end else begin
                           u8_owed = 2'd3;
                           if (b == 8'hF0) u8_rule = RULE_90_BF;
                           else if (b == 8'hF4) u8_rule = RULE_80_8F;
                        end
                     end
                  end
               end

               // Length prefix match, then the decimal value
               if (match_pos < POS_VALUE) begin
                  if (b == LEN_TAG[63 - 8 * match_pos[2:0] -: 8]) match_pos = match_pos + 4'd1;
                  else match_pos = POS_NONE;
               end else if (match_pos == POS_VALUE) begin
                  if (b == CH_NUL) begin
                     match_pos = POS_NULEND;
                  end else if (b < CH_ZERO || b > CH_NINE) begin
                     len_bad = 1'b1;
                  end else if (!len_over) begin
                     digit = {56'd0, b - CH_ZERO};
                     if (len_value > (VALUE_MAX - digit) / 64'd10) len_over = 1'b1;
                     else len_value = len_value * 64'd10 + digit;
                  end
               end
            end
         end
         default: begin
            r.cls = CLS_DROPPED;
            r.bad = 1'b1;
         end
      endcase
      return r;
   endfunction

   function automatic void report_field(input string field, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want_v, got_v);
   endfunction

   // Predict on each accepted byte, compare on each accepted result
   always @(posedge clock) begin : watch
      result_type want;
      result_type seen;
      if (reset) begin
         st_phase = PH_HEADERS;
         start_message();
         expected_q.delete();
         errors    = 0;
         checked   = 0;
         completed = 0;
      end else begin
         if (req_tvalid && req_tready) expected_q.push_back(deframe_byte(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            seen = {rsp_tdata[39:8], rsp_tuser[2], rsp_tlast, rsp_tuser[1:0], rsp_tdata[7:0]};
            if (expected_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, got byte %0h class %0d",
                        $time, seen.data, seen.cls);
            end else begin
               want = expected_q.pop_front();
               checked++;
               if (seen.done) completed++;
               if (seen.data !== want.data)
                  report_field("out_byte", 32'(want.data), 32'(seen.data));
               if (seen.cls !== want.cls)
                  report_field("byte_class", 32'(want.cls), 32'(seen.cls));
               if (seen.done !== want.done)
                  report_field("message_done", 32'(want.done), 32'(seen.done));
               if (seen.bad !== want.bad)
                  report_field("malformed", 32'(want.bad), 32'(seen.bad));
               if (seen.plen !== want.plen)
                  report_field("payload_length", want.plen, seen.plen);
            end
         end
      end
      fail_count      <= errors;
      pending         <= expected_q.size();
      results_checked <= checked;
      messages_done   <= completed;
   end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench top for the header/length message deframer: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb;

   import hlmd_pkg::*;

   localparam int unsigned ITEM_TARGET  = 1200;
   localparam int unsigned PHASE_A_END  = 420;
   localparam int unsigned PHASE_B_END  = 840;
   localparam int unsigned PRESSURE_AT  = 900;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          DRAIN_CYCLES = 12;
   localparam int          NOISE_BYTES  = 48;
   localparam logic [63:0] LEN_TAG      = "Length: ";

   // Ways the stream ends; the last one keeps it well formed
   typedef enum int {
      FAULT_BAD_LEAD,
      FAULT_COLON_OTHER,
      FAULT_COLON_LAST,
      FAULT_OPEN_AT_LF,
      FAULT_NUL_CUT,
      FAULT_NO_COLON,
      FAULT_BAD_DIGIT,
      FAULT_OVERFLOW,
      FAULT_BAD_RANGE,
      FAULT_NONE_MAX_LEN
   } fault_kind_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned results_checked;
   int unsigned messages_done;

   int unsigned    bytes_sent    = 0;
   int unsigned    send_idle_pct = 0;
   int unsigned    recv_idle_pct = 0;
   logic [7:0]     msg_q [$];
   fault_kind_type fault_kind;

   always #10 clock = ~clock;

   header_length_message_deframer_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   deframer_checker check_unit (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .fail_count      (fail_count),
      .pending         (pending),
      .results_checked (results_checked),
      .messages_done   (messages_done)
   );

   // Continuation byte, biased toward the ends of its range
   function automatic logic [7:0] cont_byte(input logic [7:0] lo, input logic [7:0] hi);
      case ($urandom_range(3))
         0:       return lo;
         1:       return hi;
         default: return 8'($urandom_range(hi, lo));
      endcase
   endfunction

   // Any byte but LF, and optionally no colon
   function automatic logic [7:0] junk_byte(input bit allow_colon);
      logic [7:0] b;
      b = 8'($urandom_range(255));
      while (b == CH_LF || (!allow_colon && b == CH_COLON)) b = 8'($urandom_range(255));
      return b;
   endfunction

   task automatic push_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
   endtask

   task automatic push_digits(input longint unsigned v);
      push_text($sformatf("%0d", v));
   endtask

   // Append one well-formed UTF-8 character, never NUL or LF
   task automatic push_char(input bit allow_colon);
      logic [7:0] lead;
      case ($urandom_range(9))
         6: begin
            msg_q.push_back(8'($urandom_range(8'hDF, 8'hC2)));
            msg_q.push_back(cont_byte(8'h80, 8'hBF));
         end
         7: begin
            lead = 8'($urandom_range(8'hEF, 8'hE0));
            msg_q.push_back(lead);
            if (lead == 8'hE0) msg_q.push_back(cont_byte(8'hA0, 8'hBF));
            else if (lead == 8'hED) msg_q.push_back(cont_byte(8'h80, 8'h9F));
            else msg_q.push_back(cont_byte(8'h80, 8'hBF));
            msg_q.push_back(cont_byte(8'h80, 8'hBF));
         end
         8, 9: begin
            lead = 8'($urandom_range(8'hF4, 8'hF0));
            msg_q.push_back(lead);
            if (lead == 8'hF0) msg_q.push_back(cont_byte(8'h90, 8'hBF));
            else if (lead == 8'hF4) msg_q.push_back(cont_byte(8'h80, 8'h8F));
            else msg_q.push_back(cont_byte(8'h80, 8'hBF));
            msg_q.push_back(cont_byte(8'h80, 8'hBF));
            msg_q.push_back(cont_byte(8'h80, 8'hBF));
         end
         default: begin
            lead = 8'($urandom_range(8'h7F, 8'h01));
            while (lead == CH_LF || (!allow_colon && lead == CH_COLON))
               lead = 8'($urandom_range(8'h7F, 8'h01));
            msg_q.push_back(lead);
         end
      endcase
   endtask

   // Build one well-formed message with random headers and payload
   task automatic build_message();
      int          choice;
      int          k;
      int          n;
      bit          len_set;
      int unsigned plen;
      len_set = 1'b0;
      plen    = 0;
      repeat ($urandom_range(3)) begin
         choice = $urandom_range(9);
         if (!len_set && choice < 4) begin
            // First Length header: optional leading zeros, empty value, NUL end
            len_set = 1'b1;
            plen    = ($urandom_range(24) == 0) ? $urandom_range(64) : $urandom_range(12);
            push_text("Length: ");
            if ($urandom_range(3) == 0) repeat ($urandom_range(3, 1)) msg_q.push_back(CH_ZERO);
            if (plen != 0 || $urandom_range(3) != 0) push_digits(plen);
            if ($urandom_range(3) == 0) begin
               msg_q.push_back(CH_NUL);
               repeat ($urandom_range(4)) msg_q.push_back(junk_byte(1'b1));
            end
         end else if (len_set && choice < 3) begin
            // Later Length header, value ignored
            push_text("Length: ");
            repeat ($urandom_range(5)) push_char(1'b1);
         end else begin
            if (choice == 9) begin
               // Near miss of the Length prefix
               k = $urandom_range(6, 1);
               for (n = 0; n < k; n++) msg_q.push_back(LEN_TAG[63 - 8 * n -: 8]);
               msg_q.push_back("x");
            end else begin
               repeat ($urandom_range(5, 1)) push_char(1'b0);
            end
            if ($urandom_range(7) == 0) begin
               msg_q.push_back(CH_NUL);
               repeat ($urandom_range(3)) msg_q.push_back(junk_byte(1'b0));
            end
            push_text(": ");
            repeat ($urandom_range(8)) push_char(1'b1);
            if ($urandom_range(5) == 0) begin
               msg_q.push_back(CH_NUL);
               repeat ($urandom_range(4)) msg_q.push_back(junk_byte(1'b1));
            end
         end
         msg_q.push_back(CH_LF);
      end
      msg_q.push_back(CH_LF);
      repeat (plen) msg_q.push_back(8'($urandom_range(255)));
   endtask

   // Offer one byte, idling at random before it; return after the transaction
   task automatic send_byte(input logic [7:0] b);
      if (bytes_sent < PHASE_A_END) begin
         send_idle_pct = 32;
         recv_idle_pct = 77;
      end else if (bytes_sent < PHASE_B_END) begin
         send_idle_pct = 77;
         recv_idle_pct = 32;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_msg();
      int i;
      for (i = 0; i < msg_q.size(); i++) send_byte(msg_q[i]);
      msg_q.delete();
   endtask

   // Receiver: random back-pressure plus one long hold
   initial begin : receiver
      int hold_left;
      bit pressure_done;
      hold_left     = 0;
      pressure_done = 1'b0;
      rsp_tready   <= 1'b0;
      forever begin
         @(posedge clock);
         if (!pressure_done && bytes_sent >= PRESSURE_AT) begin
            pressure_done = 1'b1;
            hold_left     = HOLD_CYCLES;
         end
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Stimulus and verdict
   initial begin : stimulus
      logic [7:0] b;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Lone blank line: empty message done at once
      msg_q.push_back(CH_LF);
      send_msg();
      // Short payload with extreme byte values
      push_text("Length: 2");
      msg_q.push_back(CH_LF);
      msg_q.push_back(CH_LF);
      msg_q.push_back(8'hFF);
      msg_q.push_back(CH_NUL);
      send_msg();
      // NUL stops UTF-8 checking, so the byte after it is fine
      push_text("k: ");
      msg_q.push_back(CH_NUL);
      msg_q.push_back(8'hFF);
      msg_q.push_back(CH_LF);
      msg_q.push_back(CH_LF);
      send_msg();
      // Highest code point
      push_text("k: ");
      msg_q.push_back(8'hF4);
      msg_q.push_back(8'h8F);
      msg_q.push_back(8'hBF);
      msg_q.push_back(8'hBF);
      msg_q.push_back(CH_LF);
      msg_q.push_back(CH_LF);
      send_msg();

      // Random well-formed messages
      while (bytes_sent < ITEM_TARGET) begin
         build_message();
         send_msg();
      end

      // End the stream with one fault (or a huge payload), then noise
      fault_kind = fault_kind.first();
      repeat ($urandom_range(9)) fault_kind = fault_kind.next();
      case (fault_kind)
         FAULT_BAD_LEAD: begin
            push_text("k: ");
            case ($urandom_range(2))
               0:       msg_q.push_back(8'($urandom_range(8'hC1, 8'hC0)));
               1:       msg_q.push_back(8'($urandom_range(8'hFF, 8'hF5)));
               default: msg_q.push_back(8'($urandom_range(8'hBF, 8'h80)));
            endcase
            msg_q.push_back(CH_LF);
         end
         FAULT_COLON_OTHER: begin
            push_text("k:");
            b = junk_byte(1'b1);
            while (b == CH_SPACE) b = junk_byte(1'b1);
            msg_q.push_back(b);
            msg_q.push_back(CH_LF);
         end
         FAULT_COLON_LAST: begin
            push_text("k:");
            msg_q.push_back(CH_LF);
         end
         FAULT_OPEN_AT_LF: begin
            push_text("k: ");
            msg_q.push_back(8'($urandom_range(8'hF4, 8'hC2)));
            msg_q.push_back(CH_LF);
         end
         FAULT_NUL_CUT: begin
            push_text("k: ");
            msg_q.push_back(8'($urandom_range(8'hF4, 8'hC2)));
            msg_q.push_back(CH_NUL);
            msg_q.push_back(CH_LF);
         end
         FAULT_NO_COLON: begin
            push_text("no colon");
            msg_q.push_back(CH_LF);
         end
         FAULT_BAD_DIGIT: begin
            push_text("Length: 1x2");
            msg_q.push_back(CH_LF);
            msg_q.push_back(CH_LF);
         end
         FAULT_OVERFLOW: begin
            push_text("Length: ");
            if ($urandom_range(1) == 0) push_text("4294967296");
            else push_digits(64'd4294967296 + $urandom);
            msg_q.push_back(CH_LF);
            msg_q.push_back(CH_LF);
         end
         FAULT_BAD_RANGE: begin
            push_text("k: ");
            case ($urandom_range(3))
               0: begin
                  msg_q.push_back(8'hE0);
                  msg_q.push_back(8'($urandom_range(8'h9F, 8'h80)));
               end
               1: begin
                  msg_q.push_back(8'hED);
                  msg_q.push_back(8'($urandom_range(8'hBF, 8'hA0)));
               end
               2: begin
                  msg_q.push_back(8'hF0);
                  msg_q.push_back(8'($urandom_range(8'h8F, 8'h80)));
               end
               default: begin
                  msg_q.push_back(8'hF4);
                  msg_q.push_back(8'($urandom_range(8'hBF, 8'h90)));
               end
            endcase
            msg_q.push_back(CH_LF);
         end
         default: begin
            push_text("Length: 4294967295");
            msg_q.push_back(CH_LF);
            msg_q.push_back(CH_LF);
         end
      endcase
      repeat (NOISE_BYTES) msg_q.push_back(8'($urandom_range(255)));
      send_msg();
      req_tvalid <= 1'b0;

      // Drain outstanding results, then allow for the pipeline latency
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run: %0d bytes sent, %0d results compared, %0d messages completed.",
               bytes_sent, results_checked, messages_done);
      $display("Stream closed by %s, under random gaps on both sides and a %0d-cycle hold.",
               fault_kind.name(), HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
